// ===== src/tcpeq_pkg.sv =====
// Shared types, codes and the ordering function for the two-class event queue.
package tcpeq_pkg;

    // Table geometry
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PH_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;

    // Action codes
    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_PSORT  = 3'd1;
    localparam logic [2:0] ACT_ISORT  = 3'd2;
    localparam logic [2:0] ACT_POP    = 3'd3;
    localparam logic [2:0] ACT_REMOVE = 3'd4;

    // Status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_EMPTY     = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STS_FULL      = 2'd3;

    // Class bit values
    localparam logic CLS_TAKEOFF = 1'b0;
    localparam logic CLS_LANDING = 1'b1;

    typedef struct packed {
        logic [15:0] tag;
        logic        landing;
        logic [15:0] craft_id;
    } entry_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] event_tag;
        logic        is_landing;
        logic [15:0] craft_id;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      out_tag;
        logic             out_is_landing;
        logic [15:0]      out_craft_id;
        logic [CNT_W-1:0] entry_count;
        logic             table_empty;
    } rsp_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
        logic sort;
        logic by_class;
        logic pair_left;
    } cell_ctrl_t;

    // True when a must sit behind b
    function automatic logic goes_after(entry_t a, entry_t b, logic by_class);
        logic res;
        if (by_class && (a.landing != b.landing))
        begin
            res = (a.landing == CLS_TAKEOFF) && (b.landing == CLS_LANDING);
        end
        else
        begin
            res = (a.craft_id > b.craft_id);
        end
        return res;
    endfunction

endpackage

// ===== src/tcpeq_cell.sv =====
// One table slot: holds an entry, loads, shifts from its right neighbour or swaps in a sort step.
module tcpeq_cell
    import tcpeq_pkg::*;
(
    input  logic        clk,
    input  cell_ctrl_t  ctrl,
    input  entry_t      load_entry,
    input  entry_t      left_entry,
    input  entry_t      right_entry,
    input  logic        self_valid,
    input  logic        right_valid,
    input  logic [15:0] key,
    output entry_t      entry,
    output logic        match
);

    entry_t entry_reg;
    entry_t entry_next;

    // Next entry: append load, left shift, or one compare-exchange step
    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.load)
        begin
            entry_next = load_entry;
        end
        else if (ctrl.shift)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.sort)
        begin
            if (ctrl.pair_left)
            begin
                if (right_valid && goes_after(entry_reg, right_entry, ctrl.by_class))
                begin
                    entry_next = right_entry;
                end
            end
            else
            begin
                if (self_valid && goes_after(left_entry, entry_reg, ctrl.by_class))
                begin
                    entry_next = left_entry;
                end
            end
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = self_valid && (entry_reg.tag == key);

endmodule

// ===== src/two_class_priority_event_queue_unit.sv =====
// Top level: sequencer, result register and the row of table cells.
// Append, pop, remove and unused codes: result word registered in the cycle after accept;
// one word per cycle when each result is taken at once.
// Sorts: odd-even transposition over the cell row, DEPTH (16) steps; result registered
// after the last step, and no new word is taken before that.
// Reset empties the table (count to zero); cell contents are not reset and are only
// read below the count.
module two_class_priority_event_queue_unit
    import tcpeq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SORT = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic             by_class_reg, by_class_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    entry_t           entries [DEPTH];
    cell_ctrl_t       ctrl    [DEPTH];
    logic [DEPTH-1:0] valid_vec;
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] after;
    logic             accept;
    logic             found;
    rsp_t             res;

    assign req_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Occupancy per slot
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_vec[i] = (count_reg > CNT_W'(i));
        end
    end

    // Slots at and behind the first tag match
    always_comb
    begin
        after[0] = match[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            after[i] = after[i-1] | match[i];
        end
    end
    assign found = |match;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        by_class_next  = by_class_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        res            = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            ctrl[i]          = '0;
            ctrl[i].by_class = by_class_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res.status = STS_OK;
                    unique case (req.action)
                        ACT_APPEND:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res.status = STS_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    ctrl[i].load = (count_reg == CNT_W'(i));
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_PSORT, ACT_ISORT:
                        begin
                            state_next    = ST_SORT;
                            phase_next    = '0;
                            by_class_next = (req.action == ACT_PSORT);
                        end
                        ACT_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res.status = STS_EMPTY;
                            end
                            else
                            begin
                                res.out_tag        = entries[0].tag;
                                res.out_is_landing = entries[0].landing;
                                res.out_craft_id   = entries[0].craft_id;
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    ctrl[i].shift = 1'b1;
                                end
                                count_next = count_reg - 1'b1;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res.status = STS_EMPTY;
                            end
                            else if (!found)
                            begin
                                res.status = STS_NOT_FOUND;
                            end
                            else
                            begin
                                res.out_tag = req.event_tag;
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    ctrl[i].shift = after[i];
                                end
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            res.status = STS_OK;
                        end
                    endcase

                    if ((req.action != ACT_PSORT) && (req.action != ACT_ISORT))
                    begin
                        res.entry_count = count_next;
                        res.table_empty = (count_next == '0);
                        rsp_next        = res;
                        rsp_valid_next  = 1'b1;
                    end
                end
            end
            ST_SORT:
            begin
                // Alternate even and odd pairs each cycle
                for (int i = 0; i < DEPTH; i++)
                begin
                    ctrl[i].sort      = 1'b1;
                    ctrl[i].pair_left = (1'(i) == phase_reg[0]);
                end
                phase_next = phase_reg + 1'b1;
                if (phase_reg == PH_W'(DEPTH - 1))
                begin
                    state_next      = ST_IDLE;
                    res.status      = STS_OK;
                    res.entry_count = count_reg;
                    res.table_empty = (count_reg == '0);
                    rsp_next        = res;
                    rsp_valid_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            phase_reg     <= '0;
            by_class_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            by_class_reg  <= by_class_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // Row of cells with neighbour wiring
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        entry_t load_e;
        entry_t left_e;
        entry_t right_e;
        logic   right_v;

        assign load_e.tag      = req.event_tag;
        assign load_e.landing  = req.is_landing;
        assign load_e.craft_id = req.craft_id;

        if (g == 0)
        begin : g_first
            assign left_e = entries[g];
        end
        else
        begin : g_mid_l
            assign left_e = entries[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_e = entries[g];
            assign right_v = 1'b0;
        end
        else
        begin : g_mid_r
            assign right_e = entries[g+1];
            assign right_v = valid_vec[g+1];
        end

        tcpeq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl[g]),
            .load_entry  (load_e),
            .left_entry  (left_e),
            .right_entry (right_e),
            .self_valid  (valid_vec[g]),
            .right_valid (right_v),
            .key         (req.event_tag),
            .entry       (entries[g]),
            .match       (match[g])
        );
    end

endmodule

// ===== tb/tb_two_class_priority_event_queue_unit.sv =====
// Self-checking testbench for the two-class priority event queue unit.
`timescale 1ns / 1ps

module tb_two_class_priority_event_queue_unit;
    import tcpeq_pkg::*;

    // Spare action codes: the block answers them with no change
    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd6;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;

    // Random burst shapes
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    localparam int IDLE_LIMIT   = 5000;
    localparam int PHASE_WORDS  = 425;
    localparam int REPORT_LIMIT = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Shadow copy of the table and the results it predicts
    entry_t shadow_tbl [DEPTH];
    int     shadow_cnt = 0;
    rsp_t   due_rsp [$];

    int mismatches = 0;
    int idle_cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    two_class_priority_event_queue_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // True when entry a has to sit behind entry b in the requested order
    function automatic logic trails(entry_t a, entry_t b, logic by_class);
        if (by_class && (a.landing != b.landing))
        begin
            return a.landing == CLS_TAKEOFF;
        end
        return a.craft_id > b.craft_id;
    endfunction

    // Stable insertion sort over the held entries
    function automatic void order_table(logic by_class);
        entry_t key;
        int     j;
        for (int i = 1; i < shadow_cnt; i++)
        begin
            key = shadow_tbl[i];
            j   = i;
            while (j > 0 && trails(shadow_tbl[j-1], key, by_class))
            begin
                shadow_tbl[j] = shadow_tbl[j-1];
                j--;
            end
            shadow_tbl[j] = key;
        end
    endfunction

    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < shadow_cnt; i++)
        begin
            shadow_tbl[i] = shadow_tbl[i+1];
        end
        shadow_cnt--;
    endfunction

    // Applies one action to the shadow table and returns the result word it gives
    function automatic rsp_t apply_action(req_t w);
        rsp_t o;
        int   pos;
        o   = '0;
        pos = -1;
        case (w.action)
            ACT_APPEND:
            begin
                if (shadow_cnt >= DEPTH)
                begin
                    o.status = STS_FULL;
                end
                else
                begin
                    shadow_tbl[shadow_cnt].tag      = w.event_tag;
                    shadow_tbl[shadow_cnt].landing  = w.is_landing;
                    shadow_tbl[shadow_cnt].craft_id = w.craft_id;
                    shadow_cnt++;
                end
            end
            ACT_PSORT: order_table(1'b1);
            ACT_ISORT: order_table(1'b0);
            ACT_POP:
            begin
                if (shadow_cnt == 0)
                begin
                    o.status = STS_EMPTY;
                end
                else
                begin
                    o.out_tag        = shadow_tbl[0].tag;
                    o.out_is_landing = shadow_tbl[0].landing;
                    o.out_craft_id   = shadow_tbl[0].craft_id;
                    drop_slot(0);
                end
            end
            ACT_REMOVE:
            begin
                if (shadow_cnt == 0)
                begin
                    o.status = STS_EMPTY;
                end
                else
                begin
                    for (int i = 0; i < shadow_cnt && pos < 0; i++)
                    begin
                        if (shadow_tbl[i].tag == w.event_tag)
                        begin
                            pos = i;
                        end
                    end
                    if (pos < 0)
                    begin
                        o.status = STS_NOT_FOUND;
                    end
                    else
                    begin
                        o.out_tag = w.event_tag;
                        drop_slot(pos);
                    end
                end
            end
            default: ;
        endcase
        o.entry_count = shadow_cnt[CNT_W-1:0];
        o.table_empty = (shadow_cnt == 0);
        return o;
    endfunction

    // Receiver stall, redrawn every cycle
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Monitor: predict on each accepted request, compare each accepted result
    always @(posedge clk)
    begin
        rsp_t exp_w;
        logic bad;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                due_rsp.push_back(apply_action(req));
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("%0t: result word with nothing due: %h", $time, rsp);
                    end
                end
                else
                begin
                    exp_w = due_rsp.pop_front();
                    bad = (rsp.status !== exp_w.status)
                        || (rsp.out_tag !== exp_w.out_tag)
                        || (rsp.out_is_landing !== exp_w.out_is_landing)
                        || (rsp.out_craft_id !== exp_w.out_craft_id)
                        || (rsp.entry_count !== exp_w.entry_count)
                        || (rsp.table_empty !== exp_w.table_empty);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch exp sts=%0d tag=%h land=%b id=%h cnt=%0d emp=%b",
                                $time, exp_w.status, exp_w.out_tag, exp_w.out_is_landing,
                                exp_w.out_craft_id, exp_w.entry_count, exp_w.table_empty);
                            $display("%0t:          got sts=%0d tag=%h land=%b id=%h cnt=%0d emp=%b",
                                $time, rsp.status, rsp.out_tag, rsp.out_is_landing,
                                rsp.out_craft_id, rsp.entry_count, rsp.table_empty);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on cycles where neither side moves a word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic req_t make_word(logic [2:0] act, logic [15:0] tag, logic land,
                                       logic [15:0] id);
        req_t w;
        w.action     = act;
        w.event_tag  = tag;
        w.is_landing = land;
        w.craft_id   = id;
        return w;
    endfunction

    // Sends one word; called just after a rising edge, returns at its accepting edge
    task automatic send_word(req_t w);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
    endtask

    // Tags mostly from a small pool so removes often hit
    function automatic logic [15:0] pick_tag();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 16'($urandom_range(0, 15));
        end
        else if (r < 70)
        begin
            return (r < 65) ? 16'h0000 : 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    // Ids often repeat so the sorts have ties to keep in order
    function automatic logic [15:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 16'($urandom_range(0, 7));
        end
        else if (r < 60)
        begin
            return (r < 55) ? 16'h0000 : 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    function automatic req_t random_word(int mode);
        logic [2:0] act;
        int         r;
        r = $urandom_range(0, 99);
        if (mode == MODE_FILL)
        begin
            act = (r < 85) ? ACT_APPEND : ((r < 93) ? ACT_PSORT : ACT_ISORT);
        end
        else if (mode == MODE_DRAIN)
        begin
            act = (r < 70) ? ACT_POP : ACT_REMOVE;
        end
        else if (r < 35)
        begin
            act = ACT_APPEND;
        end
        else if (r < 47)
        begin
            act = ACT_PSORT;
        end
        else if (r < 59)
        begin
            act = ACT_ISORT;
        end
        else if (r < 74)
        begin
            act = ACT_POP;
        end
        else if (r < 94)
        begin
            act = ACT_REMOVE;
        end
        else
        begin
            act = 3'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
        end
        return make_word(act, pick_tag(), 1'($urandom), pick_id());
    endfunction

    // Pops and removes on an empty table, sorts of an empty table
    task automatic test_empty_table();
        send_word(make_word(ACT_POP, 16'h1234, CLS_LANDING, 16'h4321));
        send_word(make_word(ACT_REMOVE, 16'h0005, CLS_TAKEOFF, 16'h0000));
        send_word(make_word(ACT_PSORT, 16'h0000, CLS_TAKEOFF, 16'h0000));
        send_word(make_word(ACT_ISORT, 16'hFFFF, CLS_LANDING, 16'hFFFF));
    endtask

    // Field extremes go in and come back out by pop
    task automatic test_field_extremes();
        send_word(make_word(ACT_APPEND, 16'h0000, CLS_TAKEOFF, 16'hFFFF));
        send_word(make_word(ACT_APPEND, 16'hFFFF, CLS_LANDING, 16'h0000));
        send_word(make_word(ACT_POP, 16'h0000, CLS_TAKEOFF, 16'h0000));
        send_word(make_word(ACT_POP, 16'hFFFF, CLS_LANDING, 16'hFFFF));
    endtask

    // Single-entry sort, then both orders over ties and both classes
    task automatic test_ordering();
        send_word(make_word(ACT_APPEND, 16'd1, CLS_TAKEOFF, 16'd7));
        send_word(make_word(ACT_PSORT, 16'd0, CLS_TAKEOFF, 16'd0));
        send_word(make_word(ACT_APPEND, 16'd2, CLS_LANDING, 16'd9));
        send_word(make_word(ACT_APPEND, 16'd3, CLS_TAKEOFF, 16'd7));
        send_word(make_word(ACT_APPEND, 16'd4, CLS_LANDING, 16'd2));
        send_word(make_word(ACT_APPEND, 16'd5, CLS_LANDING, 16'd9));
        send_word(make_word(ACT_PSORT, 16'd0, CLS_TAKEOFF, 16'd0));
        send_word(make_word(ACT_ISORT, 16'd0, CLS_TAKEOFF, 16'd0));
    endtask

    // Remove hit, remove miss, then pop what now heads the table
    task automatic test_remove();
        send_word(make_word(ACT_REMOVE, 16'd3, CLS_LANDING, 16'hAAAA));
        send_word(make_word(ACT_REMOVE, 16'd77, CLS_TAKEOFF, 16'h5555));
        send_word(make_word(ACT_POP, 16'd0, CLS_TAKEOFF, 16'd0));
    endtask

    task automatic test_unused_codes();
        send_word(make_word(ACT_SPARE_A, 16'd2, CLS_LANDING, 16'd9));
        send_word(make_word(ACT_SPARE_B, 16'hFFFF, CLS_TAKEOFF, 16'hFFFF));
        send_word(make_word(ACT_SPARE_C, 16'd4, CLS_LANDING, 16'd2));
    endtask

    // Bursts that fill past full, drain past empty, and mixed traffic between
    task automatic run_random_phase(int n_words);
        int sent;
        int burst;
        int mode;
        sent = 0;
        while (sent < n_words)
        begin
            case ($urandom_range(0, 9))
                0, 1:    begin mode = MODE_FILL;  burst = $urandom_range(8, 22); end
                2:       begin mode = MODE_DRAIN; burst = $urandom_range(4, 20); end
                default: begin mode = MODE_MIX;   burst = $urandom_range(1, 12); end
            endcase
            repeat (burst)
            begin
                send_word(random_word(mode));
                sent++;
            end
        end
    endtask

    task automatic test_random();
        idle_pct = 0;  stall_pct = 0;  run_random_phase(PHASE_WORDS);
        idle_pct = 54; stall_pct = 0;  run_random_phase(PHASE_WORDS);
        idle_pct = 0;  stall_pct = 54; run_random_phase(PHASE_WORDS);
        idle_pct = 17; stall_pct = 17; run_random_phase(PHASE_WORDS);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_field_extremes();
        test_ordering();
        test_remove();
        test_unused_codes();
        test_random();

        req_valid <= 1'b0;
        while (due_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DEPTH + 8) @(posedge clk);

        if (mismatches == 0 && due_rsp.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
